// File: hw/rtl/fsrw_pkg.sv
package fsrw_pkg;

   localparam int FLASH_BYTES  = 65536;
   localparam int FLASH_AW     = 16;
   localparam int SECTOR_BYTES = 128;
   localparam int SECTOR_AW    = 7;
   localparam int MAX_WRITE    = 256;
   localparam int MAX_READ     = 64;
   localparam int DRIVE_COUNT  = 2;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_ERASE = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_ADDR   = 2'd1;
   localparam logic [1:0] ST_ERASE_FAIL = 2'd2;
   localparam logic [1:0] ST_BAD_REQ    = 2'd3;

   localparam logic [1:0] REG_DRIVE0_BASE = 2'd0;
   localparam logic [1:0] REG_DRIVE0_SIZE = 2'd1;
   localparam logic [1:0] REG_DRIVE1_BASE = 2'd2;
   localparam logic [1:0] REG_DRIVE1_SIZE = 2'd3;

   typedef struct packed {
      logic [15:0] base;
      logic [16:0] size;
      logic [15:0] addr;
      logic [8:0]  len;
   } range_req_type;

endpackage

// File: hw/rtl/fsrw_range_check.sv
module fsrw_range_check (
   input  fsrw_pkg::range_req_type chk,
   output logic                    ok
);
   import fsrw_pkg::*;

   logic [17:0] addr_end;
   logic [17:0] flash_end;

   assign addr_end  = 18'(chk.addr) + 18'(chk.len);
   assign flash_end = 18'(chk.base) + addr_end;
   assign ok = (17'(chk.addr) < chk.size) && (addr_end <= 18'(chk.size))
            && (flash_end <= 18'(FLASH_BYTES));
endmodule

// File: hw/rtl/flash_sector_rmw_writer.sv
// Sequential sector read-modify-write controller over a 64 KiB byte flash held in one
// memory with one write and one registered read port. After reset a clearing pass writes
// 0xFF to every byte, one per cycle, before the first item is accepted. A write data byte
// that does not end its run is only buffered. A read gives one result per byte, each read
// from the flash and held until it is taken. A write commit merges each of its up to three
// touched sectors byte by byte, then programs a changed sector back byte by byte. An
// erase of a drive writes 0xFF to each of its sectors in turn. The single flash port
// serves all these steps, and the block takes no new item until its results are delivered.
module flash_sector_rmw_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // drive[1:0], address[17:2], length[26:18], data_byte[34:27], zero[39:35]
   input  logic [39:0] req_tdata,
   // command[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_byte[7:0], status[9:8], sectors_erased[19:10], sectors_programmed[21:20]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fsrw_pkg::*;

   typedef enum logic [11:0] {
      S_CLEAR    = 12'b000000000001,
      S_IDLE     = 12'b000000000010,
      S_CHECK    = 12'b000000000100,
      S_RD_ISSUE = 12'b000000001000,
      S_RD_WAIT  = 12'b000000010000,
      S_MG_ISSUE = 12'b000000100000,
      S_MG_PROC  = 12'b000001000000,
      S_PG_ISSUE = 12'b000010000000,
      S_PG_WRITE = 12'b000100000000,
      S_ER_CHECK = 12'b001000000000,
      S_ER_WRITE = 12'b010000000000,
      S_RESP     = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] d0_base_ff, d1_base_ff;
   logic [16:0] d0_size_ff, d1_size_ff;

   logic [7:0] flash_mem [FLASH_BYTES];
   logic [7:0] wbuf_mem  [MAX_WRITE];
   logic [7:0] mbuf_mem  [SECTOR_BYTES];
   logic [7:0] fl_rdata_ff, wb_rdata_ff, mb_rdata_ff;

   logic                fl_we;
   logic [FLASH_AW-1:0] fl_waddr, fl_raddr;
   logic [7:0]          fl_wdata;
   logic                wb_we;
   logic [7:0]          wb_raddr;
   logic                mb_we;
   logic [7:0]          mb_wdata;

   logic [15:0] clr_ff, clr_in;
   logic [8:0]  coll_ff, coll_in;
   logic [1:0]  run_drive_ff, run_drive_in;
   logic [15:0] run_addr_ff, run_addr_in;
   logic        op_read_ff, op_read_in;
   logic [1:0]  op_drive_ff, op_drive_in;
   logic [15:0] op_addr_ff, op_addr_in;
   logic [8:0]  op_len_ff, op_len_in;
   logic [17:0] sec_ff, sec_in;
   logic [17:0] end_ff, end_in;
   logic [16:0] start_ff, start_in;
   logic [16:0] stop_ff, stop_in;
   logic [6:0]  idx_ff, idx_in;
   logic        same_ff, same_in, blank_ff, blank_in;
   logic [9:0]  erased_ff, erased_in;
   logic [1:0]  prog_ff, prog_in;
   logic [15:0] rd_addr_ff, rd_addr_in;
   logic [6:0]  rd_left_ff, rd_left_in;
   logic        rd_more_ff, rd_more_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [9:0]  rsp_erased_ff, rsp_erased_in;
   logic [1:0]  rsp_prog_ff, rsp_prog_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [1:0]  in_drive;
   logic [15:0] in_addr;
   logic [8:0]  in_len;
   logic [7:0]  in_byte;
   logic [8:0]  coll_next;

   range_req_type chk;
   logic          chk_ok;
   logic [15:0]   op_base;
   logic [16:0]   op_size;
   logic [15:0]   in_base;
   logic [16:0]   in_size;
   logic [FLASH_AW-1:0] sec_addr;
   logic [16:0]   sec_next;
   logic          in_run;
   logic [7:0]    merged;
   logic          same_now, blank_now;
   logic          csr_wr;

   assign in_drive = req_tdata[1:0];
   assign in_addr  = req_tdata[17:2];
   assign in_len   = req_tdata[26:18];
   assign in_byte  = req_tdata[34:27];
   assign coll_next = coll_ff + 9'd1;

   assign in_base = (in_drive == 2'd0) ? d0_base_ff : d1_base_ff;
   assign in_size = (in_drive == 2'd0) ? d0_size_ff : d1_size_ff;
   assign op_base = (op_drive_ff == 2'd0) ? d0_base_ff : d1_base_ff;
   assign op_size = (op_drive_ff == 2'd0) ? d0_size_ff : d1_size_ff;

   assign chk.base = op_base;
   assign chk.size = op_size;
   assign chk.addr = op_addr_ff;
   assign chk.len  = op_len_ff;

   fsrw_range_check u_range (
      .chk (chk),
      .ok  (chk_ok)
   );

   assign sec_addr  = {sec_ff[FLASH_AW-1:SECTOR_AW], idx_ff};
   assign sec_next  = sec_ff[16:0] + 17'(SECTOR_BYTES);
   assign in_run    = (17'(sec_addr) >= start_ff) && (17'(sec_addr) < stop_ff);
   assign merged    = in_run ? wb_rdata_ff : fl_rdata_ff;
   assign same_now  = same_ff && (merged == fl_rdata_ff);
   assign blank_now = blank_ff && (fl_rdata_ff == 8'hFF);
   assign wb_raddr  = 8'(17'(sec_addr) - start_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_prog_ff, rsp_erased_ff, rsp_status_ff, rsp_byte_ff};

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DRIVE0_BASE: csr_prdata = 32'(d0_base_ff);
         REG_DRIVE0_SIZE: csr_prdata = 32'(d0_size_ff);
         REG_DRIVE1_BASE: csr_prdata = 32'(d1_base_ff);
         REG_DRIVE1_SIZE: csr_prdata = 32'(d1_size_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_base_ff <= 16'd0;
         d0_size_ff <= 17'd32768;
         d1_base_ff <= 16'd32768;
         d1_size_ff <= 17'd32768;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_DRIVE0_BASE: d0_base_ff <= csr_pwdata[15:0];
            REG_DRIVE0_SIZE: d0_size_ff <= csr_pwdata[16:0];
            REG_DRIVE1_BASE: d1_base_ff <= csr_pwdata[15:0];
            REG_DRIVE1_SIZE: d1_size_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fl_we) begin
         flash_mem[fl_waddr] <= fl_wdata;
      end
      fl_rdata_ff <= flash_mem[fl_raddr];
      if (wb_we) begin
         wbuf_mem[coll_ff[7:0]] <= in_byte;
      end
      wb_rdata_ff <= wbuf_mem[wb_raddr];
      if (mb_we) begin
         mbuf_mem[idx_ff] <= mb_wdata;
      end
      mb_rdata_ff <= mbuf_mem[idx_ff];
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      coll_in       = coll_ff;
      run_drive_in  = run_drive_ff;
      run_addr_in   = run_addr_ff;
      op_read_in    = op_read_ff;
      op_drive_in   = op_drive_ff;
      op_addr_in    = op_addr_ff;
      op_len_in     = op_len_ff;
      sec_in        = sec_ff;
      end_in        = end_ff;
      start_in      = start_ff;
      stop_in       = stop_ff;
      idx_in        = idx_ff;
      same_in       = same_ff;
      blank_in      = blank_ff;
      erased_in     = erased_ff;
      prog_in       = prog_ff;
      rd_addr_in    = rd_addr_ff;
      rd_left_in    = rd_left_ff;
      rd_more_in    = rd_more_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_erased_in = rsp_erased_ff;
      rsp_prog_in   = rsp_prog_ff;
      rsp_last_in   = rsp_last_ff;
      fl_we    = 1'b0;
      fl_waddr = sec_addr;
      fl_wdata = 8'hFF;
      fl_raddr = sec_addr;
      wb_we    = 1'b0;
      mb_we    = 1'b0;
      mb_wdata = merged;

      unique case (state_ff)
         S_CLEAR: begin
            fl_we    = 1'b1;
            fl_waddr = clr_ff;
            clr_in   = clr_ff + 16'd1;
            if (clr_ff == 16'(FLASH_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               rsp_byte_in   = 8'd0;
               rsp_erased_in = 10'd0;
               rsp_prog_in   = 2'd0;
               rsp_last_in   = 1'b1;
               rsp_status_in = ST_BAD_REQ;
               rd_more_in    = 1'b0;
               op_drive_in   = in_drive;
               op_addr_in    = in_addr;
               op_len_in     = in_len;
               coll_in       = 9'd0;
               case (req_tuser)
                  CMD_WRITE: begin
                     if (in_len == 9'd0 || in_len > 9'(MAX_WRITE)) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_RESP;
                     end else begin
                        wb_we = 1'b1;
                        if (coll_ff == 9'd0) begin
                           run_drive_in = in_drive;
                           run_addr_in  = in_addr;
                        end else begin
                           op_drive_in = run_drive_ff;
                           op_addr_in  = run_addr_ff;
                        end
                        op_len_in  = coll_next;
                        op_read_in = 1'b0;
                        if (coll_next >= in_len) begin
                           state_in = S_CHECK;
                        end else begin
                           coll_in = coll_next;
                        end
                     end
                  end
                  CMD_READ: begin
                     op_read_in = 1'b1;
                     if (in_drive >= 2'(DRIVE_COUNT) || in_len > 9'(MAX_READ)) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_RESP;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  CMD_ERASE: begin
                     if (in_drive >= 2'(DRIVE_COUNT)) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_RESP;
                     end else begin
                        sec_in    = 18'(in_base);
                        end_in    = 18'(in_base) + 18'(in_size);
                        erased_in = 10'd0;
                        idx_in    = 7'd0;
                        state_in  = S_ER_CHECK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_RESP;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (op_drive_ff >= 2'(DRIVE_COUNT)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else if (!chk_ok) begin
               rsp_status_in = ST_BAD_ADDR;
               rsp_valid_in  = 1'b1;
               state_in      = S_RESP;
            end else if (op_read_ff) begin
               if (op_len_ff == 9'd0) begin
                  rsp_status_in = ST_OK;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  rd_addr_in = op_base + op_addr_ff;
                  rd_left_in = op_len_ff[6:0];
                  state_in   = S_RD_ISSUE;
               end
            end else begin
               start_in  = 17'(op_base) + 17'(op_addr_ff);
               stop_in   = 17'(op_base) + 17'(op_addr_ff) + 17'(op_len_ff);
               sec_in    = 18'(op_base + op_addr_ff) & ~18'(SECTOR_BYTES - 1);
               idx_in    = 7'd0;
               same_in   = 1'b1;
               blank_in  = 1'b1;
               erased_in = 10'd0;
               prog_in   = 2'd0;
               state_in  = S_MG_ISSUE;
            end
         end
         S_RD_ISSUE: begin
            fl_raddr = rd_addr_ff;
            state_in = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            rsp_byte_in   = fl_rdata_ff;
            rsp_status_in = ST_OK;
            rsp_last_in   = (rd_left_ff == 7'd1);
            rd_more_in    = (rd_left_ff != 7'd1);
            rd_left_in    = rd_left_ff - 7'd1;
            rd_addr_in    = rd_addr_ff + 16'd1;
            rsp_valid_in  = 1'b1;
            state_in      = S_RESP;
         end
         S_MG_ISSUE: begin
            state_in = S_MG_PROC;
         end
         S_MG_PROC: begin
            mb_we    = 1'b1;
            same_in  = same_now;
            blank_in = blank_now;
            idx_in   = idx_ff + 7'd1;
            state_in = S_MG_ISSUE;
            if (idx_ff == 7'(SECTOR_BYTES - 1)) begin
               if (same_now) begin
                  sec_in   = 18'(sec_next);
                  same_in  = 1'b1;
                  blank_in = 1'b1;
                  if (sec_next >= stop_ff) begin
                     rsp_status_in = ST_OK;
                     rsp_erased_in = erased_ff;
                     rsp_prog_in   = prog_ff;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_RESP;
                  end
               end else begin
                  erased_in = erased_ff + 10'(!blank_now);
                  state_in  = S_PG_ISSUE;
               end
            end
         end
         S_PG_ISSUE: begin
            state_in = S_PG_WRITE;
         end
         S_PG_WRITE: begin
            fl_we    = 1'b1;
            fl_wdata = mb_rdata_ff;
            idx_in   = idx_ff + 7'd1;
            state_in = S_PG_ISSUE;
            if (idx_ff == 7'(SECTOR_BYTES - 1)) begin
               prog_in  = prog_ff + 2'd1;
               sec_in   = 18'(sec_next);
               same_in  = 1'b1;
               blank_in = 1'b1;
               state_in = S_MG_ISSUE;
               if (sec_next >= stop_ff) begin
                  rsp_status_in = ST_OK;
                  rsp_erased_in = erased_ff;
                  rsp_prog_in   = prog_ff + 2'd1;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_RESP;
               end
            end
         end
         S_ER_CHECK: begin
            rsp_erased_in = erased_ff;
            if (sec_ff >= end_ff) begin
               rsp_status_in = ST_OK;
               rsp_valid_in  = 1'b1;
               state_in      = S_RESP;
            end else if (sec_ff >= 18'(FLASH_BYTES)) begin
               rsp_status_in = ST_ERASE_FAIL;
               rsp_valid_in  = 1'b1;
               state_in      = S_RESP;
            end else begin
               state_in = S_ER_WRITE;
            end
         end
         S_ER_WRITE: begin
            fl_we    = 1'b1;
            idx_in   = idx_ff + 7'd1;
            if (idx_ff == 7'(SECTOR_BYTES - 1)) begin
               erased_in = erased_ff + 10'd1;
               sec_in    = sec_ff + 18'(SECTOR_BYTES);
               state_in  = S_ER_CHECK;
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = rd_more_ff ? S_RD_ISSUE : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= 16'd0;
         coll_ff      <= 9'd0;
         run_drive_ff <= 2'd0;
         run_addr_ff  <= 16'd0;
         rd_more_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         coll_ff      <= coll_in;
         run_drive_ff <= run_drive_in;
         run_addr_ff  <= run_addr_in;
         rd_more_ff   <= rd_more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_read_ff    <= op_read_in;
      op_drive_ff   <= op_drive_in;
      op_addr_ff    <= op_addr_in;
      op_len_ff     <= op_len_in;
      sec_ff        <= sec_in;
      end_ff        <= end_in;
      start_ff      <= start_in;
      stop_ff       <= stop_in;
      idx_ff        <= idx_in;
      same_ff       <= same_in;
      blank_ff      <= blank_in;
      erased_ff     <= erased_in;
      prog_ff       <= prog_in;
      rd_addr_ff    <= rd_addr_in;
      rd_left_ff    <= rd_left_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_erased_ff <= rsp_erased_in;
      rsp_prog_ff   <= rsp_prog_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_no_accept_while_result: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input accepted while a result is pending");

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("input ready during flash clearing pass");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[9:8] != ST_OK) |-> rsp_tlast)
      else $error("error result not marked last");

   a_read_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[19:10] != 10'd0) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("nonzero read byte in erase or write result");
endmodule
